// ===== hdl/shts_pkg.sv =====
// Shared types and fixed constants for the SPI transfer sequencer.
// No dependencies; imported by every module of the block.
package shts_pkg;

	// Fixed field widths
	localparam int unsigned OFF_W = 5;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned REQ_W = 16;
	localparam int unsigned TS_W  = 32;

	// Length word with the continuation flag stripped
	localparam logic [15:0] LEN_MASK = 16'h7FFF;

	typedef enum logic [1:0] {
		OP_IRQ   = 2'd0,
		OP_DONE  = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_HDR   = 4'b0010,
		PH_BODY  = 4'b0100,
		PH_WRITE = 4'b1000
	} phase_t;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_HDR   = 2'd1;
	localparam logic [1:0] KIND_BODY  = 2'd2;

	localparam logic [1:0] RC_NONE = 2'd0;
	localparam logic [1:0] RC_OK   = 2'd1;
	localparam logic [1:0] RC_BAD  = 2'd2;
	localparam logic [1:0] RC_BUSY = 2'd3;

	typedef struct packed {
		logic [1:0]       operation;
		logic [7:0]       header_byte_low;
		logic [7:0]       header_byte_high;
		logic [REQ_W-1:0] request_length;
		logic [TS_W-1:0]  event_time;
	} item_t;

	typedef struct packed {
		logic             start_transfer;
		logic [1:0]       transfer_kind;
		logic [OFF_W-1:0] transfer_offset;
		logic [LEN_W-1:0] transfer_length;
		logic             chip_select_level;
		logic             wake_level;
		logic [1:0]       reply_code;
		logic [LEN_W-1:0] reply_length;
		logic [TS_W-1:0]  reply_timestamp;
	} res_t;

endpackage

// ===== hdl/sensor_hub_spi_transfer_sequencer_core.sv =====
// Host-side SPI transfer sequencer for a sensor hub packet link: top level.
// Uses shts_pkg, shts_seq and shts_obuf.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one event per transaction:
//   interrupt notice, transfer complete, host read or host write.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   event: transfer start command, pin levels and the host reply.
// Path: a transaction is registered in the input register, processed against
//   the sequencer state, and its result is registered in the output buffer.
// Throughput: one transaction per cycle while in_stall is low; the state update
//   of the sequencer closes in one pass, so back-to-back events need no gaps.
// Reset: phase idle, no pending interrupt, lengths and timestamp zero,
//   chip select and wake released (high), all buffers empty.
// Stall: results collect in a two-entry output buffer; once it is full and
//   an event waits in the input register, in_stall rises. in_stall comes
//   straight from registers, never from out_stall.
module sensor_hub_spi_transfer_sequencer_core #(
	parameter int unsigned HEADER_BYTES = 4,
	parameter int unsigned MAX_RX_BYTES = 512,
	parameter int unsigned MAX_TX_BYTES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     operation,
	input  logic [7:0]                     header_byte_low,
	input  logic [7:0]                     header_byte_high,
	input  logic [shts_pkg::REQ_W-1:0]     request_length,
	input  logic [shts_pkg::TS_W-1:0]      event_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           start_transfer,
	output logic [1:0]                     transfer_kind,
	output logic [shts_pkg::OFF_W-1:0]     transfer_offset,
	output logic [shts_pkg::LEN_W-1:0]     transfer_length,
	output logic                           chip_select_level,
	output logic                           wake_level,
	output logic [1:0]                     reply_code,
	output logic [shts_pkg::LEN_W-1:0]     reply_length,
	output logic [shts_pkg::TS_W-1:0]      reply_timestamp
);
	import shts_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	logic  buf_full;
	logic  fire;
	logic  in_fire;
	res_t  res_c;
	res_t  head;

	assign fire     = valid_s1 && !buf_full;
	assign in_stall = valid_s1 && buf_full;
	assign in_fire  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.operation        <= operation;
			item_s1.header_byte_low  <= header_byte_low;
			item_s1.header_byte_high <= header_byte_high;
			item_s1.request_length   <= request_length;
			item_s1.event_time       <= event_time;
		end
	end

	shts_seq #(
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_RX_BYTES (MAX_RX_BYTES),
		.MAX_TX_BYTES (MAX_TX_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res_c)
	);

	shts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (fire),
		.enq_data  (res_c),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign start_transfer    = head.start_transfer;
	assign transfer_kind     = head.transfer_kind;
	assign transfer_offset   = head.transfer_offset;
	assign transfer_length   = head.transfer_length;
	assign chip_select_level = head.chip_select_level;
	assign wake_level        = head.wake_level;
	assign reply_code        = head.reply_code;
	assign reply_length      = head.reply_length;
	assign reply_timestamp   = head.reply_timestamp;

	// Checks
	a_start_selects: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_transfer |-> chip_select_level == 1'b0)
		else $error("transfer started with chip select released");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !start_transfer |->
			transfer_kind == KIND_WRITE && transfer_offset == '0 && transfer_length == '0)
		else $error("transfer fields set without a start");

	a_ts_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_code != RC_OK |-> reply_timestamp == '0)
		else $error("timestamp without accepted read");

	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

endmodule

// ===== hdl/shts_seq.sv =====
// Sequencer state and the single-pass event logic.
// Depends on shts_pkg.
module shts_seq #(
	parameter int unsigned HEADER_BYTES = 4,
	parameter int unsigned MAX_RX_BYTES = 512,
	parameter int unsigned MAX_TX_BYTES = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  shts_pkg::item_t item,
	output shts_pkg::res_t  res
);
	import shts_pkg::*;

	localparam int unsigned RX_W = $clog2(MAX_RX_BYTES + 1);
	localparam int unsigned TX_W = $clog2(MAX_TX_BYTES + 1);
	localparam logic [15:0] MAX_RX_L = 16'(MAX_RX_BYTES);
	localparam logic [15:0] MAX_TX_L = 16'(MAX_TX_BYTES);
	localparam logic [15:0] HDR_L    = 16'(HEADER_BYTES);

	phase_t            phase_q, phase_n;
	logic              irq_q, irq_n;
	logic [RX_W-1:0]   rx_len_q, rx_len_n;
	logic [TX_W-1:0]   tx_len_q, tx_len_n;
	logic [TS_W-1:0]   ts_q, ts_n;
	logic              cs_q, cs_n;
	logic              wake_q, wake_n;

	logic [15:0]       plen_raw;
	logic [15:0]       plen16;
	logic [RX_W-1:0]   plen;
	logic              try_act;

	// Payload length, flag cleared and saturated
	assign plen_raw = {item.header_byte_high, item.header_byte_low} & LEN_MASK;
	assign plen16   = (plen_raw > MAX_RX_L) ? MAX_RX_L : plen_raw;
	assign plen     = RX_W'(plen16);

	// Event handling, then activation on the updated state
	always_comb begin
		phase_n  = phase_q;
		irq_n    = irq_q;
		rx_len_n = rx_len_q;
		tx_len_n = tx_len_q;
		ts_n     = ts_q;
		cs_n     = cs_q;
		wake_n   = wake_q;
		try_act  = 1'b0;
		res      = '0;

		case (op_t'(item.operation))
			OP_IRQ: begin
				ts_n    = item.event_time;
				irq_n   = 1'b1;
				try_act = 1'b1;
			end
			OP_DONE: begin
				case (phase_q)
					PH_HDR: begin
						if (plen16 > HDR_L) begin
							phase_n               = PH_BODY;
							res.start_transfer    = 1'b1;
							res.transfer_kind     = KIND_BODY;
							res.transfer_offset   = OFF_W'(HEADER_BYTES);
							res.transfer_length   = LEN_W'(plen - RX_W'(HEADER_BYTES));
						end else begin
							cs_n     = 1'b1;
							rx_len_n = '0;
							phase_n  = PH_IDLE;
							try_act  = 1'b1;
						end
					end
					PH_BODY: begin
						cs_n     = 1'b1;
						rx_len_n = plen;
						phase_n  = PH_IDLE;
						try_act  = 1'b1;
					end
					PH_WRITE: begin
						cs_n     = 1'b1;
						rx_len_n = (16'(tx_len_q) < plen16) ? RX_W'(tx_len_q) : plen;
						tx_len_n = '0;
						phase_n  = PH_IDLE;
						try_act  = 1'b1;
					end
					default: begin
						// completion while idle is ignored
					end
				endcase
			end
			OP_READ: begin
				if (rx_len_q != '0) begin
					if (item.request_length >= 16'(rx_len_q)) begin
						res.reply_code      = RC_OK;
						res.reply_length    = LEN_W'(rx_len_q);
						res.reply_timestamp = ts_q;
					end else begin
						res.reply_code = RC_BAD;
					end
					rx_len_n = '0;
					try_act  = 1'b1;
				end
			end
			OP_WRITE: begin
				if (item.request_length > MAX_TX_L) begin
					res.reply_code = RC_BAD;
				end else if (tx_len_q != '0) begin
					res.reply_code = RC_BUSY;
				end else begin
					tx_len_n         = TX_W'(item.request_length);
					res.reply_code   = RC_OK;
					res.reply_length = LEN_W'(item.request_length);
					wake_n           = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// Start the next transfer once idle, drained and signalled
		if (try_act && phase_n == PH_IDLE && rx_len_n == '0 && irq_n) begin
			irq_n               = 1'b0;
			cs_n                = 1'b0;
			res.start_transfer  = 1'b1;
			res.transfer_offset = '0;
			if (tx_len_n != '0) begin
				phase_n             = PH_WRITE;
				res.transfer_kind   = KIND_WRITE;
				res.transfer_length = LEN_W'(tx_len_n);
				wake_n              = 1'b1;
			end else begin
				phase_n             = PH_HDR;
				res.transfer_kind   = KIND_HDR;
				res.transfer_length = LEN_W'(HEADER_BYTES);
			end
		end

		res.chip_select_level = cs_n;
		res.wake_level        = wake_n;
	end

	// State update on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			irq_q    <= 1'b0;
			rx_len_q <= '0;
			tx_len_q <= '0;
			ts_q     <= '0;
			cs_q     <= 1'b1;
			wake_q   <= 1'b1;
		end else if (fire) begin
			phase_q  <= phase_n;
			irq_q    <= irq_n;
			rx_len_q <= rx_len_n;
			tx_len_q <= tx_len_n;
			ts_q     <= ts_n;
			cs_q     <= cs_n;
			wake_q   <= wake_n;
		end
	end

endmodule

// ===== hdl/shts_obuf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on shts_pkg.
module shts_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enq,
	input  shts_pkg::res_t  enq_data,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output shts_pkg::res_t  head
);
	import shts_pkg::*;

	res_t head_q;
	res_t skid_q;
	logic head_vld_q;
	logic skid_vld_q;
	logic deq;

	assign deq       = head_vld_q && !out_stall;
	assign full      = skid_vld_q;
	assign out_valid = head_vld_q;
	assign head      = head_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (deq) skid_vld_q <= 1'b0;
			end else if (head_vld_q) begin
				if (!deq) begin
					skid_vld_q <= enq;
				end else begin
					head_vld_q <= enq;
				end
			end else begin
				head_vld_q <= enq;
			end
		end
	end

	// Payload movement
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (deq) head_q <= skid_q;
		end else if (enq) begin
			if (!head_vld_q || deq) head_q <= enq_data;
			else skid_q <= enq_data;
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sensor_hub_spi_transfer_sequencer_core.
// Depends on shts_pkg and the sequencer RTL. A scoreboard class predicts each result;
// tasks drive directed events, then random event sequences, under varying back-pressure.
module testbench;
	import shts_pkg::*;

	localparam int unsigned HEADER_BYTES   = 4;
	localparam int unsigned MAX_RX_BYTES   = 512;
	localparam int unsigned MAX_TX_BYTES   = 256;
	localparam int unsigned RESET_CYCLES   = 9;
	localparam int unsigned PHASE_ITEMS    = 176;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned QUIET_LIMIT    = 2000;

	// Expected behaviour of the sequencer, one result per accepted event
	class transfer_scoreboard;
		phase_t      link_phase = PH_IDLE;
		bit          irq_pending = 1'b0;
		int unsigned rx_len = 0;
		int unsigned tx_len = 0;
		logic [31:0] stamp = '0;
		logic        cs_level = 1'b1;
		logic        wake = 1'b1;
		res_t        next_res;
		res_t        awaited_results[$];
		int unsigned errors = 0;

		function void start_xfer(logic [1:0] kind, int unsigned off, int unsigned len);
			next_res.start_transfer  = 1'b1;
			next_res.transfer_kind   = kind;
			next_res.transfer_offset = OFF_W'(off);
			next_res.transfer_length = LEN_W'(len);
		endfunction

		// Kick off the next transfer once idle, empty and an interrupt is waiting
		function void activate();
			if (link_phase != PH_IDLE || rx_len != 0 || !irq_pending)
				return;
			irq_pending = 1'b0;
			cs_level = 1'b0;
			if (tx_len != 0) begin
				link_phase = PH_WRITE;
				start_xfer(KIND_WRITE, 0, tx_len);
				wake = 1'b1;
			end else begin
				link_phase = PH_HDR;
				start_xfer(KIND_HDR, 0, HEADER_BYTES);
			end
		endfunction

		function void note_event(item_t it);
			logic [15:0] word;
			int unsigned plen;
			next_res = '0;
			word = {it.header_byte_high, it.header_byte_low} & LEN_MASK;
			plen = (word > MAX_RX_BYTES) ? MAX_RX_BYTES : word;
			case (op_t'(it.operation))
				OP_IRQ: begin
					stamp = it.event_time;
					irq_pending = 1'b1;
					activate();
				end
				OP_DONE: begin
					case (link_phase)
						PH_HDR: begin
							if (plen > HEADER_BYTES) begin
								link_phase = PH_BODY;
								start_xfer(KIND_BODY, HEADER_BYTES, plen - HEADER_BYTES);
							end else begin
								cs_level = 1'b1;
								rx_len = 0;
								link_phase = PH_IDLE;
								activate();
							end
						end
						PH_BODY: begin
							cs_level = 1'b1;
							rx_len = plen;
							link_phase = PH_IDLE;
							activate();
						end
						PH_WRITE: begin
							cs_level = 1'b1;
							rx_len = (tx_len < plen) ? tx_len : plen;
							tx_len = 0;
							link_phase = PH_IDLE;
							activate();
						end
						default: ;
					endcase
				end
				OP_READ: begin
					if (rx_len != 0) begin
						if (it.request_length >= rx_len) begin
							next_res.reply_code      = RC_OK;
							next_res.reply_length    = LEN_W'(rx_len);
							next_res.reply_timestamp = stamp;
						end else begin
							next_res.reply_code = RC_BAD;
						end
						rx_len = 0;
						activate();
					end
				end
				default: begin
					if (it.request_length > MAX_TX_BYTES) begin
						next_res.reply_code = RC_BAD;
					end else if (tx_len != 0) begin
						next_res.reply_code = RC_BUSY;
					end else begin
						tx_len = it.request_length;
						next_res.reply_code   = RC_OK;
						next_res.reply_length = LEN_W'(it.request_length);
						wake = 1'b0;
					end
				end
			endcase
			next_res.chip_select_level = cs_level;
			next_res.wake_level        = wake;
			awaited_results.push_back(next_res);
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_reply(res_t got);
			res_t want;
			if (awaited_results.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
				return;
			end
			want = awaited_results.pop_front();
			compare("start_transfer", want.start_transfer, got.start_transfer);
			compare("transfer_kind", want.transfer_kind, got.transfer_kind);
			compare("transfer_offset", want.transfer_offset, got.transfer_offset);
			compare("transfer_length", want.transfer_length, got.transfer_length);
			compare("chip_select_level", want.chip_select_level, got.chip_select_level);
			compare("wake_level", want.wake_level, got.wake_level);
			compare("reply_code", want.reply_code, got.reply_code);
			compare("reply_length", want.reply_length, got.reply_length);
			compare("reply_timestamp", want.reply_timestamp, got.reply_timestamp);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        operation = '0;
	logic [7:0]        header_byte_low = '0;
	logic [7:0]        header_byte_high = '0;
	logic [REQ_W-1:0]  request_length = '0;
	logic [TS_W-1:0]   event_time = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              start_transfer;
	logic [1:0]        transfer_kind;
	logic [OFF_W-1:0]  transfer_offset;
	logic [LEN_W-1:0]  transfer_length;
	logic              chip_select_level;
	logic              wake_level;
	logic [1:0]        reply_code;
	logic [LEN_W-1:0]  reply_length;
	logic [TS_W-1:0]   reply_timestamp;

	transfer_scoreboard sb = new();
	int unsigned send_idle_pct = 22;
	int unsigned stall_pct = 67;
	int unsigned quiet_cycles = 0;

	sensor_hub_spi_transfer_sequencer_core #(
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_RX_BYTES(MAX_RX_BYTES),
		.MAX_TX_BYTES(MAX_TX_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.header_byte_low(header_byte_low),
		.header_byte_high(header_byte_high),
		.request_length(request_length),
		.event_time(event_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.start_transfer(start_transfer),
		.transfer_kind(transfer_kind),
		.transfer_offset(transfer_offset),
		.transfer_length(transfer_length),
		.chip_select_level(chip_select_level),
		.wake_level(wake_level),
		.reply_code(reply_code),
		.reply_length(reply_length),
		.reply_timestamp(reply_timestamp)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {start_transfer, transfer_kind, transfer_offset, transfer_length,
				chip_select_level, wake_level, reply_code, reply_length, reply_timestamp};
			sb.check_reply(got);
		end
	end

	// Watchdog: ends the run if no transaction moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic item_t make_event(op_t op, logic [7:0] lo, logic [7:0] hi,
			logic [15:0] req, logic [31:0] stamp_in);
		item_t it;
		it.operation        = op;
		it.header_byte_low  = lo;
		it.header_byte_high = hi;
		it.request_length   = req;
		it.event_time       = stamp_in;
		return it;
	endfunction

	// Random event, steered by the predicted state so that whole packet
	// sequences get through; a share of arbitrary noise is mixed in
	function automatic item_t pick_event();
		item_t it;
		op_t op;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 12)
			op = op_t'($urandom_range(3));
		else if (sb.link_phase != PH_IDLE)
			op = (roll < 80) ? OP_DONE : OP_IRQ;
		else if (sb.rx_len != 0)
			op = (roll < 70) ? OP_READ : OP_WRITE;
		else
			op = (roll < 55) ? OP_IRQ : OP_WRITE;
		it.operation = op;
		it.event_time = $urandom;
		it.header_byte_low = 8'($urandom_range(255));
		case ($urandom_range(9))
			0, 1: begin
				// packet lengths from zero up to two bytes past the header
				it.header_byte_high = 8'h00;
				it.header_byte_low  = 8'($urandom_range(HEADER_BYTES + 2));
			end
			2, 3, 4, 5: it.header_byte_high = 8'($urandom_range(1));
			6: it.header_byte_high = 8'h80 | 8'($urandom_range(1));
			default: it.header_byte_high = 8'($urandom_range(255));
		endcase
		roll = $urandom_range(99);
		if (op == OP_READ && sb.rx_len != 0) begin
			if (roll < 40)
				it.request_length = 16'(sb.rx_len + $urandom_range(20));
			else if (roll < 55)
				it.request_length = 16'(sb.rx_len);
			else if (roll < 80)
				it.request_length = 16'($urandom_range(sb.rx_len - 1));
			else
				it.request_length = 16'($urandom_range(16'hFFFF));
		end else if (op == OP_WRITE && roll < 80) begin
			it.request_length = 16'($urandom_range(MAX_TX_BYTES + 1));
		end else begin
			it.request_length = 16'($urandom_range(16'hFFFF));
		end
		return it;
	endfunction

	// Present one event and hold it until the block takes the transaction
	task automatic send_event(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{operation, header_byte_low, header_byte_high, request_length, event_time} <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_event(it);
	endtask

	// Hold off the sender until every result has been returned
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited_results.size() != 0);
	endtask

	initial begin
		item_t directed[$];
		int unsigned send_pcts[3];
		int unsigned stall_pcts[3];
		send_pcts  = '{22, 67, 0};
		stall_pcts = '{67, 22, 0};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation, pin behaviour and corner of the length fields
		directed = '{
			make_event(OP_READ,  8'h00, 8'h00, 16'hFFFF, 32'h0),        // read, nothing held
			make_event(OP_DONE,  8'hFF, 8'hFF, 16'h0000, 32'h0),        // completion while idle
			make_event(OP_IRQ,   8'h00, 8'h00, 16'h0000, 32'hFFFF_FFFF),
			make_event(OP_IRQ,   8'h00, 8'h00, 16'h0000, 32'h0000_0000), // irq mid-transfer
			make_event(OP_DONE,  8'h03, 8'h00, 16'h0000, 32'h0),        // short header, re-arms
			make_event(OP_DONE,  8'h04, 8'h00, 16'h0000, 32'h0),        // length equals header
			make_event(OP_IRQ,   8'h00, 8'h00, 16'h0000, 32'h1234_5678),
			make_event(OP_DONE,  8'hFF, 8'hFF, 16'h0000, 32'h0),        // flag stripped, saturates
			make_event(OP_DONE,  8'hFF, 8'hFF, 16'h0000, 32'h0),        // body done
			make_event(OP_WRITE, 8'h00, 8'h00, 16'd257,  32'h0),        // write too long
			make_event(OP_WRITE, 8'h00, 8'h00, 16'd256,  32'h0),        // largest write
			make_event(OP_WRITE, 8'h00, 8'h00, 16'd1,    32'h0),        // transmit busy
			make_event(OP_READ,  8'h00, 8'h00, 16'd511,  32'h0),        // buffer too small
			make_event(OP_IRQ,   8'h00, 8'h00, 16'h0000, 32'hA5A5_5A5A), // write transfer
			make_event(OP_DONE,  8'h05, 8'h80, 16'h0000, 32'h0),        // write done
			make_event(OP_READ,  8'h00, 8'h00, 16'd5,    32'h0),        // exact fit
			make_event(OP_WRITE, 8'h00, 8'h00, 16'd0,    32'h0),        // zero-length write
			make_event(OP_IRQ,   8'h00, 8'h00, 16'h0000, 32'h0000_0001),
			make_event(OP_DONE,  8'h05, 8'h00, 16'h0000, 32'h0),        // one-byte body
			make_event(OP_IRQ,   8'h00, 8'h00, 16'h0000, 32'h0000_0002), // irq during body
			make_event(OP_DONE,  8'h05, 8'h00, 16'h0000, 32'h0),        // packet held, no restart
			make_event(OP_READ,  8'h00, 8'h00, 16'hFFFF, 32'h0),        // read restarts header
			make_event(OP_DONE,  8'h00, 8'h00, 16'h0000, 32'h0),        // empty header
			make_event(OP_WRITE, 8'h00, 8'h00, 16'hFFFF, 32'h0)
		};
		foreach (directed[i])
			send_event(directed[i]);
		drain();

		// Random sequences under three back-pressure profiles
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = send_pcts[p];
			stall_pct = stall_pcts[p];
			repeat (PHASE_ITEMS)
				send_event(pick_event());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sensor_hub_spi_transfer_sequencer_core.f =====
hdl/shts_pkg.sv
hdl/shts_seq.sv
hdl/shts_obuf.sv
hdl/sensor_hub_spi_transfer_sequencer_core.sv
test/testbench.sv
